@@ rtl/ppt_pkg.sv @@
// package for the pareto path table: status and state codes, compare results
// no dependencies
`default_nettype none
package ppt_pkg;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdW = 16;
  localparam int unsigned RowW = 32;
  localparam int unsigned FuzzW = 18;
  localparam int unsigned OneQ16 = 65536;
  localparam logic [FuzzW-1:0] FuzzReset = 18'd66191;

  typedef enum logic [2:0] {
    ST_EVICT  = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_FULL   = 3'd3,
    ST_REPORT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMP_EQUAL     = 2'd0,
    CMP_BETTER1   = 2'd1,
    CMP_BETTER2   = 2'd2,
    CMP_DIFFERENT = 2'd3
  } cmp_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

@@ rtl/ppt_fuzzy_cmp.sv @@
// fuzzy pareto compare of two cost pairs by scaled product compares, one after another; go is taken only while idle
// depends on ppt_pkg
`default_nettype none
module ppt_fuzzy_cmp #(
  parameter int unsigned COST_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    go_i,
  input  wire logic [COST_WIDTH-1:0]   s1_i,
  input  wire logic [COST_WIDTH-1:0]   t1_i,
  input  wire logic [COST_WIDTH-1:0]   s2_i,
  input  wire logic [COST_WIDTH-1:0]   t2_i,
  input  wire logic [ppt_pkg::FuzzW-1:0] fuzz_i,
  output logic                         done_o,
  output ppt_pkg::cmp_e                fuzzy_o,
  output ppt_pkg::cmp_e                exact_o
);
  import ppt_pkg::*;
  localparam int unsigned PW = COST_WIDTH + FuzzW;

  // eight steps: fuzzy t1>t2, t2>t1, s1>s2, s2>s1 then the same exact
  logic [3:0] step_q, step_d;
  logic       busy_q, busy_d;
  logic [7:0] gt_q, gt_d;
  logic [COST_WIDTH-1:0] a, b;
  logic [FuzzW-1:0] f;
  logic [PW-1:0] pb_q;
  logic [PW-1:0] pb;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin a = t1_i; b = t2_i; end
      2'd1: begin a = t2_i; b = t1_i; end
      2'd2: begin a = s1_i; b = s2_i; end
      default: begin a = s2_i; b = s1_i; end
    endcase
    f = step_q[2] ? FuzzW'(OneQ16) : fuzz_i;
    pb = PW'(b) * PW'(f);
  end

  logic       phase_q;
  logic [COST_WIDTH-1:0] a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      phase_q <= busy_d ? ~phase_q & busy_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    gt_q <= gt_d;
    pb_q <= pb;
    a_q <= a;
  end

  // product registered, compare the following cycle
  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    gt_d = gt_q;
    done_o = 1'b0;
    if (!busy_q) begin
      if (go_i) begin
        busy_d = 1'b1;
        step_d = '0;
      end
    end else if (phase_q) begin
      gt_d[step_q[2:0]] = (PW'({a_q, 16'd0})) > pb_q;
      if (step_q == 4'd7) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
      step_d = step_q + 4'd1;
    end
  end

  function automatic cmp_e resolve(input logic [3:0] g);
    cmp_e r;
    if (g[0]) r = g[3] ? CMP_DIFFERENT : CMP_BETTER2;
    else if (g[1]) r = g[2] ? CMP_DIFFERENT : CMP_BETTER1;
    else if (g[2]) r = CMP_BETTER2;
    else if (g[3]) r = CMP_BETTER1;
    else r = CMP_EQUAL;
    return r;
  endfunction

  assign fuzzy_o = resolve(gt_d[3:0]);
  assign exact_o = resolve(gt_d[7:4]);

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_q)
    else $error("done outside compare");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy_q)
    else $error("compare did not finish");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> step_q <= 4'd7)
    else $error("step out of range");
endmodule
`default_nettype wire

@@ rtl/pareto_path_table.sv @@
// top level of the pareto path table: sequencer, entry memory, report scan
// depends on ppt_pkg and ppt_fuzzy_cmp
//
// An add walks the stored entries in cost order; each entry costs one memory
// read plus a pass through the shared product/compare unit, and entries that
// are kept are compacted in place. Insertion then shifts the tail up one entry
// a cycle. busy is high throughout an add or a report. Each result is on
// result_valid_o for exactly one cycle and cannot be stalled; the final one
// carries last_o.
`default_nettype none
module pareto_path_table #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned COST_WIDTH = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      kind_i,
  input  wire logic [15:0]               plan_id_i,
  input  wire logic [31:0]               startup_cost_i,
  input  wire logic [31:0]               total_cost_i,
  input  wire logic [31:0]               row_estimate_i,
  input  wire logic                      skip_for_cheapest_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [17:0]               cfg_data_i,
  output logic                           result_valid_o,
  output logic [2:0]                     status_o,
  output logic [15:0]                    first_id_o,
  output logic [15:0]                    second_id_o,
  output logic                           found_o,
  output logic                           last_o
);
  import ppt_pkg::*;
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = IdW + 2 * COST_WIDTH + RowW + 1;

  typedef struct packed {
    logic [IdW-1:0]        id;
    logic [COST_WIDTH-1:0] sc;
    logic [COST_WIDTH-1:0] tc;
    logic [RowW-1:0]       rows;
    logic                  skip;
  } entry_t;

  logic [EW-1:0] mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rd_q <= mem[raddr];
  end

  logic [FuzzW-1:0] fuzz_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fuzz_q <= FuzzReset;
    else if (cfg_valid_i) fuzz_q <= cfg_data_i;
  end

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;   // entry count
  logic [CW-1:0] i_q, i_d;       // read index
  logic [CW-1:0] w_q, w_d;       // write index
  logic [CW-1:0] ins_q, ins_d;
  logic          acc_q, acc_d;
  logic          kind_q;
  entry_t        new_q;
  logic          fnd_q, fnd_d;
  entry_t        bs_q, bs_d, bt_q, bt_d;
  logic          rvalid_q, rvalid_d;  // rd_q holds entry i_q-1
  logic          res_v_d;
  status_e       res_st_d;
  logic [15:0]   res_a_d, res_b_d;
  logic          res_f_d, res_l_d;
  logic          cmp_go, cmp_done;
  cmp_e          fz, ex;

  ppt_fuzzy_cmp #(.COST_WIDTH(COST_WIDTH)) u_cmp (
    .clk_i, .rst_ni, .go_i(cmp_go),
    .s1_i(new_q.sc), .t1_i(new_q.tc), .s2_i(rd_q.sc), .t2_i(rd_q.tc),
    .fuzz_i(fuzz_q), .done_o(cmp_done), .fuzzy_o(fz), .exact_o(ex)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      result_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; w_q <= w_d; ins_q <= ins_d; acc_q <= acc_d;
    fnd_q <= fnd_d; bs_q <= bs_d; bt_q <= bt_d; rvalid_q <= rvalid_d;
    status_o <= res_st_d; first_id_o <= res_a_d; second_id_o <= res_b_d;
    found_o <= res_f_d; last_o <= res_l_d;
    if (start && !busy) begin
      kind_q <= kind_i;
      new_q <= '{id: plan_id_i, sc: COST_WIDTH'(startup_cost_i),
                 tc: COST_WIDTH'(total_cost_i), rows: row_estimate_i,
                 skip: skip_for_cheapest_i};
    end
  end

  assign busy = (state_q != S_IDLE);

  logic rm, rej;
  always_comb begin
    rm = 1'b0; rej = 1'b0;
    unique case (fz)
      CMP_EQUAL: begin
        if (new_q.rows < rd_q.rows) rm = 1'b1;
        else if (new_q.rows > rd_q.rows) rej = 1'b1;
        else if (ex == CMP_BETTER1) rm = 1'b1;
        else rej = 1'b1;
      end
      CMP_BETTER1: rm = (new_q.rows <= rd_q.rows);
      CMP_BETTER2: rej = (new_q.rows >= rd_q.rows);
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; w_d = w_q; ins_d = ins_q;
    acc_d = acc_q; fnd_d = fnd_q; bs_d = bs_q; bt_d = bt_q; rvalid_d = 1'b0;
    res_v_d = 1'b0; res_st_d = ST_EVICT; res_a_d = '0; res_b_d = '0;
    res_f_d = 1'b0; res_l_d = 1'b0;
    raddr = i_q[AW-1:0]; rd_en = 1'b1; we = 1'b0; waddr = w_q[AW-1:0]; wdata = rd_q;
    cmp_go = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          i_d = '0; w_d = '0; ins_d = '0; acc_d = 1'b1; fnd_d = 1'b0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        // rd_q valid the cycle after address i_q is presented
        if (kind_q) begin
          if (rvalid_q && !rd_q.skip) begin
            fnd_d = 1'b1;
            if (!fnd_q) begin
              bs_d = rd_q; bt_d = rd_q;
            end else begin
              if ({bs_q.sc, bs_q.tc} >= {rd_q.sc, rd_q.tc}) bs_d = rd_q;
              if ({bt_q.tc, bt_q.sc} >= {rd_q.tc, rd_q.sc}) bt_d = rd_q;
            end
          end
          if (i_q < cnt_q) begin
            i_d = i_q + CW'(1); rvalid_d = 1'b1;
          end else if (!rvalid_q) begin
            res_v_d = 1'b1; res_st_d = ST_REPORT; res_l_d = 1'b1;
            res_f_d = fnd_q;
            res_a_d = fnd_q ? bt_q.id : '0;
            res_b_d = fnd_q ? bs_q.id : '0;
            state_d = S_IDLE;
          end
        end else if (rvalid_q) begin
          if (acc_q) begin
            // hold the entry under compare
            rd_en = 1'b0;
            cmp_go = 1'b1;
            state_d = S_CMP;
          end else begin
            // copy remaining entries down
            we = 1'b1; w_d = w_q + CW'(1);
            if (i_q < cnt_q) begin
              i_d = i_q + CW'(1); rvalid_d = 1'b1;
            end
          end
        end else if (i_q < cnt_q) begin
          i_d = i_q + CW'(1); rvalid_d = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CMP: begin
        rd_en = 1'b0;
        if (cmp_done) begin
          if (rm) begin
            res_v_d = 1'b1; res_st_d = ST_EVICT; res_a_d = rd_q.id;
          end else begin
            if (rej) acc_d = 1'b0;
            else if (new_q.tc >= rd_q.tc) ins_d = w_q + CW'(1);
            we = 1'b1; w_d = w_q + CW'(1);
          end
          state_d = S_READ;
        end
      end
      S_DONE: begin
        cnt_d = w_q;
        if (!acc_q) begin
          res_v_d = 1'b1; res_st_d = ST_REJECT; res_a_d = new_q.id;
          res_l_d = 1'b1; state_d = S_IDLE;
        end else if (w_q >= CW'(TABLE_DEPTH)) begin
          res_v_d = 1'b1; res_st_d = ST_FULL; res_a_d = new_q.id;
          res_l_d = 1'b1; state_d = S_IDLE;
        end else begin
          i_d = w_q; state_d = S_SHIFT;
          raddr = AW'(w_q - CW'(1));
        end
      end
      S_SHIFT: begin
        // i_q is the slot to fill; rd_q holds entry i_q-1 the cycle after its read
        if (i_q > ins_q) begin
          if (rvalid_q) begin
            we = 1'b1; waddr = i_q[AW-1:0]; wdata = rd_q;
            i_d = i_q - CW'(1);
            raddr = AW'(i_q - CW'(2));
          end else begin
            raddr = AW'(i_q - CW'(1));
            rvalid_d = 1'b1;
          end
          if (rvalid_q && (i_q - CW'(1)) > ins_q) rvalid_d = 1'b1;
          else if (rvalid_q) rvalid_d = 1'b0;
        end else begin
          we = 1'b1; waddr = ins_q[AW-1:0]; wdata = new_q;
          cnt_d = w_q + CW'(1);
          res_v_d = 1'b1; res_st_d = ST_ACCEPT; res_a_d = new_q.id;
          res_l_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final result while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start not taken");
endmodule
`default_nettype wire
